// ===== hw/rtl/aes256_pkg.sv =====
`default_nettype none
package aes256_pkg;

  localparam int ROUNDS_DEF    = 14;
  localparam int KEY_WORDS_DEF = 8;
  localparam int CFG_IDX_W     = 2;

  localparam logic [CFG_IDX_W-1:0] REG_KEY0 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY1 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY3 = 2'd3;

  localparam logic OP_ENCRYPT = 1'b0;
  localparam logic OP_DECRYPT = 1'b1;

  typedef struct packed {
    logic        operation;
    logic [63:0] block_high;
    logic [63:0] block_low;
  } aes_in_t;

  typedef struct packed {
    logic [63:0] result_high;
    logic [63:0] result_low;
  } aes_out_t;

  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
    return t[x];
  endfunction

  function automatic logic [7:0] inv_sbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
    return t[x];
  endfunction

  function automatic logic [7:0] xt(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sbox_word(input logic [31:0] w);
    return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/aes256_keyexp.sv =====
`default_nettype none
module aes256_keyexp
  import aes256_pkg::*;
#(
  parameter int ROUNDS    = ROUNDS_DEF,
  parameter int KEY_WORDS = KEY_WORDS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic [255:0] key,
  input  wire logic        restart,
  input  wire logic [$clog2(ROUNDS+1)-1:0] rd_round,
  output logic [127:0]     rd_key,
  output logic             ready
);
  localparam int SCHED = 4 * (ROUNDS + 1);
  localparam int IW    = $clog2(SCHED + 1);

  // round keys kept as 128-bit rows, one row per round
  logic [127:0] mem [ROUNDS+1];
  logic [31:0]  win_r [KEY_WORDS];
  logic [IW-1:0] idx_r;
  logic [7:0]   rcon_r;
  logic         busy_r;
  logic [31:0]  t_w, new_w;
  logic [127:0] row_r;

  always_comb begin
    t_w = win_r[KEY_WORDS-1];
    if (idx_r[2:0] == 3'd0) t_w = sbox_word({t_w[23:0], t_w[31:24]}) ^ {rcon_r, 24'h0};
    else if (idx_r[2:0] == 3'd4) t_w = sbox_word(t_w);
    new_w = win_r[0] ^ t_w;
  end

  assign ready  = !busy_r;
  assign rd_key = row_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      idx_r  <= IW'(KEY_WORDS);
      rcon_r <= 8'h01;
      for (int i = 0; i < KEY_WORDS; i++) win_r[i] <= '0;
    end else if (restart) begin
      busy_r <= 1'b1;
      idx_r  <= IW'(KEY_WORDS);
      rcon_r <= 8'h01;
      for (int i = 0; i < KEY_WORDS; i++) win_r[i] <= key[255-32*i -: 32];
    end else if (busy_r) begin
      for (int i = 0; i < KEY_WORDS-1; i++) win_r[i] <= win_r[i+1];
      win_r[KEY_WORDS-1] <= new_w;
      if (idx_r[2:0] == 3'd0) rcon_r <= xt(rcon_r);
      idx_r <= idx_r + 1'b1;
      if (idx_r == IW'(SCHED - 1)) busy_r <= 1'b0;
    end
  end

  // row written once its four words sit at the top of the window
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      // reset key is all zero
      mem[0] <= '0;
      mem[1] <= '0;
    end else if (restart) begin
      mem[0] <= key[255:128];
      mem[1] <= key[127:0];
    end else if (busy_r && idx_r[1:0] == 2'd3) begin
      mem[idx_r[IW-1:2]] <= {win_r[KEY_WORDS-3], win_r[KEY_WORDS-2],
                             win_r[KEY_WORDS-1], new_w};
    end
    if (int'(rd_round) <= ROUNDS) row_r <= mem[rd_round];
  end
endmodule
`default_nettype wire

// ===== hw/rtl/aes256_round.sv =====
`default_nettype none
module aes256_round
  import aes256_pkg::*;
(
  input  wire logic [127:0] st,
  input  wire logic         dec,
  input  wire logic         last,
  input  wire logic [127:0] rk,
  output logic [127:0]      q
);
  logic [7:0] b [16];
  logic [7:0] s [16];
  logic [7:0] m [16];
  logic [7:0] a [16];
  logic [7:0] x2, x4, x8, c0, c1, c2, c3;

  always_comb begin
    x2 = 8'h00;
    x4 = 8'h00;
    x8 = 8'h00;
    for (int i = 0; i < 16; i++) b[i] = st[127-8*i -: 8];
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++) begin
        if (dec) s[r + 4*((c+r)&3)] = inv_sbox(b[r+4*c]);
        else     s[r + 4*c] = sbox(b[r + 4*((c+r)&3)]);
      end
    // decrypt adds key before inverse mix
    for (int i = 0; i < 16; i++) a[i] = dec ? s[i] ^ rk[127-8*i -: 8] : s[i];
    for (int c = 0; c < 4; c++) begin
      c0 = a[4*c]; c1 = a[4*c+1]; c2 = a[4*c+2]; c3 = a[4*c+3];
      if (dec) begin
        for (int r = 0; r < 4; r++) begin
          m[4*c+r] = 8'h00;
          for (int k = 0; k < 4; k++) begin
            x2 = xt(a[4*c+k]); x4 = xt(x2); x8 = xt(x4);
            case ((k - r + 4) & 3)
              0: m[4*c+r] = m[4*c+r] ^ x8 ^ x4 ^ x2;
              1: m[4*c+r] = m[4*c+r] ^ x8 ^ x2 ^ a[4*c+k];
              2: m[4*c+r] = m[4*c+r] ^ x8 ^ x4 ^ a[4*c+k];
              default: m[4*c+r] = m[4*c+r] ^ x8 ^ a[4*c+k];
            endcase
          end
        end
      end else begin
        m[4*c]   = xt(c0) ^ xt(c1) ^ c1 ^ c2 ^ c3;
        m[4*c+1] = c0 ^ xt(c1) ^ xt(c2) ^ c2 ^ c3;
        m[4*c+2] = c0 ^ c1 ^ xt(c2) ^ xt(c3) ^ c3;
        m[4*c+3] = xt(c0) ^ c0 ^ c1 ^ c2 ^ xt(c3);
      end
    end
    for (int i = 0; i < 16; i++) begin
      if (last) q[127-8*i -: 8] = s[i] ^ rk[127-8*i -: 8];
      else if (dec) q[127-8*i -: 8] = m[i];
      else q[127-8*i -: 8] = m[i] ^ rk[127-8*i -: 8];
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/aes256_block_cipher_core.sv =====
`default_nettype none
// channel | ports                       | handshake
// input   | in_start, in_busy, in_word  | taken when in_start && !in_busy
// result  | out_valid, out_word         | one-cycle strobe, no backpressure
// config  | cfg_we, cfg_index, cfg_data | taken when cfg_we
// A block: the accept edge fetches the first round key, the fetch state adds
// it, then 14 rounds, one per cycle, on the shared round unit. out_valid
// rises with the registered last round; a new block is taken only from then on.
// After reset or a key write the schedule is rebuilt, and in_busy stays
// high meanwhile. The receiver cannot stall.
module aes256_block_cipher_core
  import aes256_pkg::*;
#(
  parameter int ROUNDS    = ROUNDS_DEF,
  parameter int KEY_WORDS = KEY_WORDS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_start,
  output logic                      in_busy,
  input  wire aes_in_t              in_word,
  output logic                      out_valid,
  output aes_out_t                  out_word,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [63:0]          cfg_data
);
  localparam int RW = $clog2(ROUNDS + 1);

  typedef enum logic [1:0] {S_IDLE, S_FETCH, S_RUN} state_t;

  state_t        state_r;
  logic [255:0]  key_r;
  logic          kx_restart_r;
  logic [127:0]  st_r;
  logic          dec_r;
  logic [RW-1:0] rnd_r, rd_round, cnt_r;
  logic [127:0]  rk, rq;
  logic          kready, last;

  aes256_keyexp #(.ROUNDS(ROUNDS), .KEY_WORDS(KEY_WORDS)) u_kx (
    .clk(clk), .rst_n(rst_n), .key(key_r), .restart(kx_restart_r),
    .rd_round(rd_round), .rd_key(rk), .ready(kready));

  assign last = (cnt_r == RW'(ROUNDS));

  aes256_round u_rnd (.st(st_r), .dec(dec_r), .last(last), .rk(rk), .q(rq));

  assign in_busy = (state_r != S_IDLE) || !kready || kx_restart_r;

  always_comb begin
    rd_round = rnd_r;
    if (state_r == S_IDLE)
      rd_round = (in_word.operation == OP_DECRYPT) ? RW'(ROUNDS) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid    <= 1'b0;
      kx_restart_r <= 1'b0;
      key_r        <= '0;
    end else begin
      out_valid    <= 1'b0;
      kx_restart_r <= 1'b0;
      if (cfg_we) begin
        kx_restart_r <= 1'b1;
        case (cfg_index)
          REG_KEY0: key_r[255:192] <= cfg_data;
          REG_KEY1: key_r[191:128] <= cfg_data;
          REG_KEY2: key_r[127:64]  <= cfg_data;
          REG_KEY3: key_r[63:0]    <= cfg_data;
          default:  kx_restart_r   <= 1'b0;
        endcase
      end
      case (state_r)
        S_IDLE: begin
          if (in_start && !in_busy) begin
            st_r  <= {in_word.block_high, in_word.block_low};
            dec_r <= in_word.operation;
            rnd_r <= (in_word.operation == OP_DECRYPT) ? RW'(ROUNDS - 1) : RW'(1);
            cnt_r <= RW'(1);
            state_r <= S_FETCH;
          end
        end
        S_FETCH: begin
          // rk holds the first round key now
          st_r    <= st_r ^ rk;
          rnd_r   <= dec_r ? rnd_r - 1'b1 : rnd_r + 1'b1;
          state_r <= S_RUN;
        end
        S_RUN: begin
          st_r  <= rq;
          cnt_r <= cnt_r + 1'b1;
          rnd_r <= dec_r ? rnd_r - 1'b1 : rnd_r + 1'b1;
          if (last) begin
            out_valid <= 1'b1;
            out_word  <= aes_out_t'(rq);
            state_r   <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== tb/aes256_checker.sv =====
module aes256_checker
  import aes256_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_start,
  input  wire logic                 in_busy,
  input  wire aes_in_t              in_word,
  input  wire logic                 out_valid,
  input  wire aes_out_t             out_word,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [63:0]          cfg_data,
  output int                        mismatches,
  output int                        outstanding
);

  localparam logic [7:0] FWD_SUB [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};

  localparam logic [7:0] MIX_FWD [4] = '{8'd2, 8'd3, 8'd1, 8'd1};
  localparam logic [7:0] MIX_INV [4] = '{8'd14, 8'd11, 8'd13, 8'd9};

  logic [7:0]  inv_sub [256];
  logic [63:0] key_reg [4];
  logic [31:0] sched [60];
  aes_out_t    expected_q [$];

  initial begin
    for (int i = 0; i < 256; i++) inv_sub[FWD_SUB[i]] = i[7:0];
  end

  function automatic logic [7:0] gmul(logic [7:0] a, logic [7:0] b);
    logic [7:0] acc;
    acc = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) acc ^= a;
      a = a[7] ? ((a << 1) ^ 8'h1b) : (a << 1);
    end
    return acc;
  endfunction

  function automatic logic [31:0] sub4(logic [31:0] x);
    return {FWD_SUB[x[31:24]], FWD_SUB[x[23:16]], FWD_SUB[x[15:8]], FWD_SUB[x[7:0]]};
  endfunction

  task automatic expand_key();
    logic [255:0] k;
    logic [31:0]  t;
    logic [7:0]   rc;
    k  = {key_reg[0], key_reg[1], key_reg[2], key_reg[3]};
    rc = 8'h01;
    for (int i = 0; i < 8; i++) sched[i] = k[255-32*i -: 32];
    for (int i = 8; i < 60; i++) begin
      t = sched[i-1];
      if (i % 8 == 0) begin
        t  = sub4({t[23:0], t[31:24]}) ^ {rc, 24'h0};
        rc = gmul(rc, 8'h02);
      end else if (i % 8 == 4) begin
        t = sub4(t);
      end
      sched[i] = sched[i-8] ^ t;
    end
  endtask

  function automatic logic [127:0] add_rk(logic [127:0] s, int rnd);
    return s ^ {sched[4*rnd], sched[4*rnd+1], sched[4*rnd+2], sched[4*rnd+3]};
  endfunction

  // byte i of the state sits at bits 127-8i; column c holds bytes 4c..4c+3
  function automatic logic [127:0] sub_shift(logic [127:0] s, logic inv);
    logic [127:0] t;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++) begin
        if (inv)
          t[127-8*(r+4*((c+r)&3)) -: 8] = inv_sub[s[127-8*(r+4*c) -: 8]];
        else
          t[127-8*(r+4*c) -: 8] = FWD_SUB[s[127-8*(r+4*((c+r)&3)) -: 8]];
      end
    return t;
  endfunction

  function automatic logic [127:0] mix(logic [127:0] s, logic inv);
    logic [127:0] t;
    logic [7:0]   v;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++) begin
        v = 8'h00;
        for (int k = 0; k < 4; k++)
          v ^= gmul(s[127-8*(4*c+k) -: 8], inv ? MIX_INV[(k-r+4)&3] : MIX_FWD[(k-r+4)&3]);
        t[127-8*(4*c+r) -: 8] = v;
      end
    return t;
  endfunction

  function automatic aes_out_t transform_block(aes_in_t w);
    logic [127:0] s;
    aes_out_t     o;
    s = {w.block_high, w.block_low};
    if (w.operation == OP_ENCRYPT) begin
      s = add_rk(s, 0);
      for (int r = 1; r < 14; r++) s = add_rk(mix(sub_shift(s, 1'b0), 1'b0), r);
      s = add_rk(sub_shift(s, 1'b0), 14);
    end else begin
      s = add_rk(s, 14);
      for (int r = 13; r > 0; r--) s = mix(add_rk(sub_shift(s, 1'b1), r), 1'b1);
      s = add_rk(sub_shift(s, 1'b1), 0);
    end
    o.result_high = s[127:64];
    o.result_low  = s[63:0];
    return o;
  endfunction

  task automatic report(string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  initial mismatches = 0;
  assign outstanding = expected_q.size();

  always @(posedge clk) begin
    aes_out_t e;
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) key_reg[i] = 64'h0;
      expand_key();
      expected_q.delete();
    end else begin
      if (out_valid) begin
        if (expected_q.size() == 0) begin
          report($sformatf("unexpected word %h", out_word));
        end else begin
          e = expected_q.pop_front();
          if (out_word.result_high !== e.result_high)
            report($sformatf("result_high %h, want %h", out_word.result_high, e.result_high));
          if (out_word.result_low !== e.result_low)
            report($sformatf("result_low %h, want %h", out_word.result_low, e.result_low));
        end
      end
      if (in_start && !in_busy) expected_q.push_back(transform_block(in_word));
      if (cfg_we) begin
        key_reg[cfg_index] = cfg_data;
        expand_key();
      end
    end
  end

endmodule

// ===== tb/tb_aes256_block_cipher_core.sv =====
module tb_aes256_block_cipher_core;
  import aes256_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_start = 1'b0;
  logic                 in_busy;
  aes_in_t              in_word = '0;
  logic                 out_valid;
  aes_out_t             out_word;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_KEY0;
  logic [63:0]          cfg_data = 64'h0;
  int                   mismatches;
  int                   outstanding;
  int                   cycles = 0;
  int                   idle_pct = 0;
  int                   blocks_sent = 0;
  int                   key_writes = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  aes256_block_cipher_core dut (
    .clk, .rst_n, .in_start, .in_busy, .in_word,
    .out_valid, .out_word, .cfg_we, .cfg_index, .cfg_data
  );

  aes256_checker chk (
    .clk, .rst_n, .in_start, .in_busy, .in_word,
    .out_valid, .out_word, .cfg_we, .cfg_index, .cfg_data,
    .mismatches, .outstanding
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb_aes256_block_cipher_core: errors");
      $finish;
    end
  end

  task automatic send_block(logic op, logic [63:0] hi, logic [63:0] lo);
    in_start <= 1'b1;
    in_word  <= '{operation: op, block_high: hi, block_low: lo};
    @(posedge clk);
    while (in_busy) @(posedge clk);
    blocks_sent++;
    while ($urandom_range(0, 99) < idle_pct) begin
      in_start <= 1'b0;
      @(posedge clk);
    end
  endtask

  // drop start, let every word come back, then allow for the pipeline
  task automatic drain();
    in_start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (24) @(posedge clk);
  endtask

  task automatic write_key(logic [CFG_IDX_W-1:0] idx, logic [63:0] data);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    key_writes++;
  endtask

  task automatic load_key(logic [63:0] k0, logic [63:0] k1, logic [63:0] k2, logic [63:0] k3);
    write_key(REG_KEY0, k0);
    write_key(REG_KEY1, k1);
    write_key(REG_KEY2, k2);
    write_key(REG_KEY3, k3);
  endtask

  function automatic logic [63:0] rand_half();
    case ($urandom_range(0, 9))
      0: return 64'h0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic edge_blocks();
    send_block(OP_ENCRYPT, 64'h0, 64'h0);
    send_block(OP_DECRYPT, 64'h0, 64'h0);
    send_block(OP_ENCRYPT, '1, '1);
    send_block(OP_DECRYPT, '1, '1);
    send_block(OP_ENCRYPT, 64'haaaaaaaaaaaaaaaa, 64'h5555555555555555);
    send_block(OP_DECRYPT, 64'h5555555555555555, 64'haaaaaaaaaaaaaaaa);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int p = 0; p < 8; p++) begin
      idle_pct = (p < 3) ? 8 : (p < 6) ? 66 : 0;
      case (p)
        0: edge_blocks();  // schedule from the reset key
        1: load_key('1, '1, '1, '1);
        2: begin
          load_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f,
                   64'h1011121314151617, 64'h18191a1b1c1d1e1f);
          send_block(OP_ENCRYPT, 64'h0011223344556677, 64'h8899aabbccddeeff);
          send_block(OP_DECRYPT, 64'h8ea2b7ca516745bf, 64'heafc49904b496089);
          edge_blocks();
        end
        3: write_key(REG_KEY2, {$urandom, $urandom});  // partial key update
        4: load_key(64'h0, 64'h0, 64'h0, 64'h0);
        default: load_key({$urandom, $urandom}, {$urandom, $urandom},
                          {$urandom, $urandom}, {$urandom, $urandom});
      endcase
      for (int n = 0; n < 150; n++) begin
        if (p == 5 && n == 75) drain();
        send_block(1'($urandom_range(0, 1)), rand_half(), rand_half());
      end
    end

    drain();
    $display("blocks: %0d through 8 key settings, %0d key register writes",
             blocks_sent, key_writes);
    $display("sender gaps at 8%% and 66%% and none, one full drain mid-stream");
    if (mismatches == 0 && outstanding == 0) begin
      $display("tb_aes256_block_cipher_core: clean");
    end else begin
      $display("tb_aes256_block_cipher_core: errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/aes256_pkg.sv
hw/rtl/aes256_keyexp.sv
hw/rtl/aes256_round.sv
hw/rtl/aes256_block_cipher_core.sv
tb/aes256_checker.sv
tb/tb_aes256_block_cipher_core.sv
